@@ design/pds_pkg.sv @@
// Shared types for the painter depth sorter: record layout and cell control.
`timescale 1ns / 1ps

package pds_pkg;

    // One stored polygon record
    typedef struct packed {
        logic [3:0]         obj;
        logic [15:0]        poly;
        logic signed [31:0] depth;
    } t_rec;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the broadcast record
        logic shift;  // move every record one cell toward the head
    } t_cell_ctl;

    localparam int unsigned RecBits  = $bits(t_rec);
    localparam int unsigned DataBits = ((RecBits + 7) / 8) * 8;

endpackage

@@ design/pds_cell.sv @@
// One cell of the insertion chain: holds a record, compares, takes from neighbors.
`timescale 1ns / 1ps

module pds_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pds_pkg::t_cell_ctl i_ctl,
    input  pds_pkg::t_rec     i_new,        // broadcast incoming record
    input  pds_pkg::t_rec     i_prev_rec,   // neighbor toward the head
    input  logic              i_prev_valid,
    input  logic              i_prev_gt,    // neighbor keeps its record
    input  pds_pkg::t_rec     i_next_rec,   // neighbor toward the tail
    input  logic              i_next_valid,
    output pds_pkg::t_rec     o_rec,
    output logic              o_valid,
    output logic              o_gt
);
    import pds_pkg::*;

    t_rec r_rec, n_rec;
    logic r_valid, n_valid;

    // Strictly farther than the newcomer: the newcomer lands behind us
    assign o_gt = r_valid && (r_rec.depth > i_new.depth);

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (!o_gt) begin
                if (i_prev_gt) begin
                    n_rec   = i_new;
                    n_valid = 1'b1;
                end else begin
                    n_rec   = i_prev_rec;
                    n_valid = i_prev_valid;
                end
            end
        end else if (i_ctl.shift) begin
            n_rec   = i_next_rec;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;

endmodule

@@ design/painter_depth_sorter_core.sv @@
// Painter's-algorithm depth sorter: systolic insertion chain with streaming ports.
// Load: one record request per cycle, placed in sorted order in the same cycle.
// Emission starts in the cycle after the request marked last; records leave head
// cell first at full rate while tready is high; input is held off during emission.
// Frame-to-frame turnaround: the cycle after the final record is taken, input opens.
// Reset (synchronous, active low) empties every cell and clears the overflow flag.
`timescale 1ns / 1ps

module painter_depth_sorter_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input records
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [3:0] object_id, [19:4] polygon_index, [51:20] depth_key, [55:52] zero
    input  logic [pds_pkg::DataBits-1:0] i_s_axis_tdata,
    input  logic                         i_s_axis_tlast,   // last_record
    // sorted output records
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [3:0] out_object, [19:4] out_polygon, [51:20] out_depth, [55:52] zero
    output logic [pds_pkg::DataBits-1:0] o_m_axis_tdata,
    output logic                         o_m_axis_tlast,   // run_end
    output logic                         o_m_axis_tuser    // [0] overflowed
);
    import pds_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;

    t_rec      w_new;
    t_cell_ctl w_ctl;
    logic      w_in_acc, w_out_acc, w_full;

    t_rec w_rec      [CAPACITY];
    logic w_valid    [CAPACITY];
    logic w_gt       [CAPACITY];
    t_rec w_prev_rec [CAPACITY];
    logic w_prev_val [CAPACITY];
    logic w_prev_gt  [CAPACITY];
    t_rec w_next_rec [CAPACITY];
    logic w_next_val [CAPACITY];

    // unpack the incoming record
    assign w_new.obj   = i_s_axis_tdata[3:0];
    assign w_new.poly  = i_s_axis_tdata[19:4];
    assign w_new.depth = $signed(i_s_axis_tdata[51:20]);

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // tail cell occupied: the store is full and new records are dropped
    assign w_full = w_valid[CAPACITY-1];

    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.shift = w_out_acc;

    // neighbor wiring; head sees an always-farther neighbor, tail sees an empty one
    for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
        if (g == 0) begin : g_head
            assign w_prev_rec[g] = w_new;
            assign w_prev_val[g] = 1'b0;
            assign w_prev_gt[g]  = 1'b1;
        end else begin : g_mid
            assign w_prev_rec[g] = w_rec[g-1];
            assign w_prev_val[g] = w_valid[g-1];
            assign w_prev_gt[g]  = w_gt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_rec[g] = w_rec[g];
            assign w_next_val[g] = 1'b0;
        end else begin : g_body
            assign w_next_rec[g] = w_rec[g+1];
            assign w_next_val[g] = w_valid[g+1];
        end

        pds_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_prev_rec   (w_prev_rec[g]),
            .i_prev_valid (w_prev_val[g]),
            .i_prev_gt    (w_prev_gt[g]),
            .i_next_rec   (w_next_rec[g]),
            .i_next_valid (w_next_val[g]),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    // sequencing: load until a last request, then drain the chain from the head
    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    n_ovf = r_ovf | w_full;
                    if (i_s_axis_tlast) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc && o_m_axis_tlast) begin
                    n_state = ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    // output straight from the head cell's registers
    assign o_m_axis_tvalid = (r_state == ST_EMIT) && w_valid[0];
    assign o_m_axis_tdata  = {{(DataBits - RecBits){1'b0}},
                              w_rec[0].depth, w_rec[0].poly, w_rec[0].obj};
    assign o_m_axis_tlast  = !w_valid[1];
    assign o_m_axis_tuser  = r_ovf;

    // never accepting and offering at once
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("input and output open together");

    // a last request always yields a run in the next cycle
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("no output after last request");

    // depth order nonincreasing inside a run
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && (w_rec[0].depth <= $past(w_rec[0].depth))))
        else $error("depth order broken");

    // overflow flag sticks while loading
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && r_ovf) |=> r_ovf)
        else $error("overflow flag lost during load");

endmodule
